@@ design/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffra_pkg: shared constants and types of the run allocator
// Sizes of the slot map, owner table and the request record passed from the
// front part to the back part.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int SLOTS       = 1024;
    localparam int OWNERS      = 128;
    localparam int MAX_RUN     = 32;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int OWNER_W     = $clog2(OWNERS);
    localparam int LEN_W       = 6;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [0:0] CFG_SLOTS  = 1'b0;
    localparam logic [0:0] CFG_OWNERS = 1'b1;

    // Request record: refused marks a request rejected by the front part.
    typedef struct packed {
        logic               command;
        logic [OWNER_W-1:0] owner_id;
        logic [LEN_W-1:0]   run_length;
        logic               refused;
    } ffra_req_t;

endpackage

@@ design/first_fit_run_allocator_core.sv @@
// ----------------------------------------------------------------------------
// first_fit_run_allocator_core: first-fit contiguous run allocator
// A refused request is answered directly; an allocate scans up to the run's
// last slot (on a miss, all searched slots) and marks the run; a release
// fetches and clears the run. One request at a time in the back part, set by
// the one-slot-per-cycle scan. After reset a clearing pass over all slots
// runs; requests queue (two deep) but are not served.
// ----------------------------------------------------------------------------
module first_fit_run_allocator_core import ffra_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command, owner_id[6:0], run_length[5:0], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // accepted, pad
);

    logic [10:0] slots_reg;
    logic [7:0]  owners_reg;
    logic        q_valid, q_pop;
    ffra_req_t   q_head;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg  <= 11'(SLOTS);
            owners_reg <= 8'(OWNERS);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SLOTS:  slots_reg  <= cfg_data;
                CFG_OWNERS: owners_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ffra_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .owner_limit(owners_reg), .q_valid, .q_pop, .q_head
    );

    ffra_back u_back (
        .aclk, .aresetn, .q_valid, .q_pop, .q_head,
        .slots_in_use(slots_reg), .m_tvalid, .m_tready, .m_tdata
    );

endmodule

@@ design/ffra_front.sv @@
// ----------------------------------------------------------------------------
// ffra_front: request intake and classification
// Accepts requests, checks the owner id (and an allocate's run length) against
// the limits, and pushes a classified record into a two-entry queue.
// ----------------------------------------------------------------------------
module ffra_front import ffra_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,
    input  logic [7:0]         owner_limit,
    output logic               q_valid,
    input  logic               q_pop,
    output ffra_req_t          q_head
);

    ffra_req_t               q_mem [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]         count_reg;
    ffra_req_t               req;
    logic                    push;
    logic [8:0]              owners_eff;

    assign s_tready = (count_reg != QDEPTH[QPTR_W:0]);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_head   = q_mem[rd_ptr_reg];

    // Classify: owner limit is clamped to OWNERS
    always_comb begin
        owners_eff     = (owner_limit > OWNERS[7:0] && OWNERS < 256) ?
                         9'(OWNERS) : {1'b0, owner_limit};
        req.command    = s_tdata[0];
        req.owner_id   = s_tdata[OWNER_W:1];
        req.run_length = s_tdata[OWNER_W+LEN_W:OWNER_W+1];
        req.refused    = ({2'b0, req.owner_id} >= owners_eff);
        if (req.command == CMD_ALLOC &&
            (req.run_length == '0 || req.run_length > LEN_W'(MAX_RUN)))
            req.refused = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            q_mem[wr_ptr_reg] <= req;
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
        end
    end

endmodule

@@ design/ffra_back.sv @@
// ----------------------------------------------------------------------------
// ffra_back: slot map search and update
// Scans the slot map one slot per cycle for the first free run, marks or
// clears the run, keeps the owner table and drives the answer register.
// ----------------------------------------------------------------------------
module ffra_back import ffra_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  ffra_req_t          q_head,
    input  logic [10:0]        slots_in_use,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_FETCH, S_FREE, S_DONE
    } state_t;

    state_t              state_reg;
    logic                slot_map [SLOTS];
    logic [OWNERS-1:0]   holds_reg;
    logic [SLOT_W-1:0]   own_start [OWNERS];
    logic [LEN_W-1:0]    own_len [OWNERS];
    logic [CNT_W-1:0]    pos_reg;
    logic [LEN_W-1:0]    streak_reg;
    logic [SLOT_W-1:0]   first_reg;
    logic [LEN_W-1:0]    left_reg;
    ffra_req_t           cur_reg;
    logic                ok_reg;
    logic                out_valid_reg;
    logic [CNT_W-1:0]    limit;
    logic                slot_q_reg;
    logic [SLOT_W-1:0]   rd_addr;
    logic                hit;
    logic [SLOT_W-1:0]   hit_start;
    logic [SLOT_W-1:0]   start_q_reg;
    logic [LEN_W-1:0]    len_q_reg;

    assign limit    = (slots_in_use > 11'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_in_use);
    assign q_pop    = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, ok_reg};

    // Read one slot ahead so the registered data matches pos_reg in S_SCAN
    assign rd_addr   = (state_reg == S_SCAN) ? pos_reg[SLOT_W-1:0] + 1'b1 : '0;
    assign hit       = (state_reg == S_SCAN) && (pos_reg < limit) && !slot_q_reg &&
                       (streak_reg + 1'b1 == cur_reg.run_length);
    assign hit_start = SLOT_W'(pos_reg + 1'b1 - CNT_W'(cur_reg.run_length));

    // Slot map: clearing pass, set and clear one slot a cycle, registered read
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR)
            slot_map[pos_reg[SLOT_W-1:0]] <= 1'b0;
        else if (state_reg == S_MARK || state_reg == S_FREE)
            slot_map[first_reg] <= (state_reg == S_MARK);
        slot_q_reg <= slot_map[rd_addr];
    end

    // Owner table: written on a found run, read at the queue head
    always_ff @(posedge aclk) begin
        if (hit) begin
            own_start[cur_reg.owner_id] <= hit_start;
            own_len[cur_reg.owner_id]   <= cur_reg.run_length;
        end
        start_q_reg <= own_start[q_head.owner_id];
        len_q_reg   <= own_len[q_head.owner_id];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            pos_reg       <= '0;
            holds_reg     <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == CNT_W'(SLOTS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (q_pop) begin
                        cur_reg    <= q_head;
                        pos_reg    <= '0;
                        streak_reg <= '0;
                        if (q_head.refused) begin
                            ok_reg    <= 1'b0;
                            state_reg <= S_DONE;
                        end else if (q_head.command == CMD_RELEASE) begin
                            if (holds_reg[q_head.owner_id]) begin
                                holds_reg[q_head.owner_id] <= 1'b0;
                                state_reg <= S_FETCH;
                                ok_reg    <= 1'b1;
                            end else begin
                                ok_reg    <= 1'b0;
                                state_reg <= S_DONE;
                            end
                        end else if (holds_reg[q_head.owner_id]) begin
                            ok_reg    <= 1'b0;
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (pos_reg >= limit) begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_DONE;
                    end else if (slot_q_reg) begin
                        streak_reg <= '0;
                        pos_reg    <= pos_reg + 1'b1;
                    end else if (streak_reg + 1'b1 == cur_reg.run_length) begin
                        first_reg <= hit_start;
                        left_reg  <= cur_reg.run_length;
                        holds_reg[cur_reg.owner_id] <= 1'b1;
                        ok_reg    <= 1'b1;
                        state_reg <= S_MARK;
                    end else begin
                        streak_reg <= streak_reg + 1'b1;
                        pos_reg    <= pos_reg + 1'b1;
                    end
                end
                // Owner table data, registered at the pop, is ready in the cycle after the pop
                S_FETCH: begin
                    first_reg <= start_q_reg;
                    left_reg  <= len_q_reg;
                    state_reg <= S_FREE;
                end
                S_MARK, S_FREE: begin
                    first_reg <= first_reg + 1'b1;
                    left_reg  <= left_reg - 1'b1;
                    if (left_reg == LEN_W'(1))
                        state_reg <= S_DONE;
                end
                S_DONE: begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
